// File: rtl/wsel_pkg.sv
// ----------------------------------------------------------------------------
// wsel_pkg
// Shared types, constants and helpers for the weighted server selector.
// ----------------------------------------------------------------------------
`default_nettype none

package wsel_pkg;

    localparam int DEF_MAX_SERVERS  = 4;
    localparam int DEF_COUNTER_BITS = 32;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 10;
    localparam int SEL_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ZERO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TWO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THREE  = 3'd6;

    localparam logic [1:0] MODE_WEIGHTED    = 2'd0;
    localparam logic [1:0] MODE_ROUND_ROBIN = 2'd1;
    localparam logic [1:0] MODE_RANDOM      = 2'd2;

    typedef struct packed {
        logic [31:0] original_dest;
        logic        pool_hit;
    } t_in;

    typedef struct packed {
        logic             use_original;
        logic [SEL_W-1:0] server_sel;
        logic [31:0]      dest_out;
    } t_out;

    typedef struct packed {
        logic [1:0]             mode;
        logic [2:0]             server_count;
        logic [3:0]             avail_mask;
        logic [3:0][STEP_W-1:0] step;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_BUMP,
        ST_RAND,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PATH_ORIG,
        PATH_SCAN,
        PATH_RAND
    } t_path;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic bump;
        logic rand_pick;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_path path;
        logic  scan_last;
        logic  out_free;
    } t_stat;

    // 4 is 1 mod 3, so the sum of base-4 digits keeps the residue
    function automatic logic [1:0] mod3_u16(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 4'(s[4:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        if (u >= 3'd3) begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
    endfunction

endpackage

`default_nettype wire

// File: rtl/wsel_ctrl.sv
// ----------------------------------------------------------------------------
// wsel_ctrl
// Sequencer for one request: decide, scan servers or pick at random, update, hand over result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsel_ctrl
    import wsel_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                case (i_stat.path)
                    PATH_SCAN: n_state = ST_SCAN;
                    PATH_RAND: n_state = ST_RAND;
                    default:   n_state = ST_FINISH;
                endcase
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_BUMP;
            end
            ST_BUMP:   n_state = ST_FINISH;
            ST_RAND:   n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: o_cmd.clear     = 1'b1;
            ST_SCAN:   o_cmd.scan      = 1'b1;
            ST_BUMP:   o_cmd.bump      = 1'b1;
            ST_RAND:   o_cmd.rand_pick = 1'b1;
            ST_FINISH: o_cmd.emit      = i_stat.out_free;
            default:   o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/wsel_dp.sv
// ----------------------------------------------------------------------------
// wsel_dp
// Request registers, server counters, compare unit, LFSR and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsel_dp
    import wsel_pkg::*;
#(
    parameter int MAX_SERVERS  = DEF_MAX_SERVERS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_in  i_in,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out      o_out
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [2:0] MAX_N = 3'(MAX_SERVERS);

    logic [31:0]             r_dest;
    logic                    r_hit;
    logic [IDX_W:0]          r_idx;
    logic [SEL_W-1:0]        r_sel;
    logic [COUNTER_BITS-1:0] r_best;
    logic                    r_found;
    logic                    r_use_orig;
    logic [15:0]             r_lfsr;
    logic [COUNTER_BITS-1:0] r_cnt [MAX_SERVERS];
    logic                    r_out_valid;
    t_out                    r_out;

    logic [2:0]              n_srv;
    logic [IDX_W-1:0]        addr;
    logic [1:0]              addr2;
    logic [STEP_W-1:0]       inc;
    logic [COUNTER_BITS-1:0] cnt_rd;
    logic [COUNTER_BITS:0]   sum;
    logic [COUNTER_BITS-1:0] cnt_sat;
    logic                    avail;
    logic [SEL_W-1:0]        rand_sel;

    assign n_srv  = (i_cfg.server_count > MAX_N) ? MAX_N : i_cfg.server_count;
    assign addr   = i_cmd.bump ? r_sel[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign addr2  = 2'(addr);
    assign inc    = (i_cfg.mode == MODE_WEIGHTED) ? i_cfg.step[addr2] : STEP_W'(1);
    assign avail  = i_cfg.avail_mask[addr2];
    assign cnt_rd = r_cnt[addr];
    assign sum    = {1'b0, cnt_rd} + (COUNTER_BITS + 1)'(inc);
    assign cnt_sat = sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];

    always_comb begin
        case (n_srv)
            3'd2:    rand_sel = SEL_W'(r_lfsr[0]);
            3'd3:    rand_sel = mod3_u16(r_lfsr);
            default: rand_sel = r_lfsr[1:0];
        endcase
    end

    always_comb begin
        o_stat.path = PATH_ORIG;
        if (r_hit && n_srv != 3'd0) begin
            if (i_cfg.mode == MODE_WEIGHTED || i_cfg.mode == MODE_ROUND_ROBIN) begin
                o_stat.path = PATH_SCAN;
            end else if (i_cfg.mode == MODE_RANDOM && n_srv >= 3'd2) begin
                o_stat.path = PATH_RAND;
            end
        end
        o_stat.scan_last = (3'(r_idx) + 3'd1) >= n_srv;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dest <= i_in.original_dest;
            r_hit  <= i_in.pool_hit;
        end
        if (i_cmd.clear) begin
            r_idx      <= '0;
            r_sel      <= '0;
            r_found    <= 1'b0;
            r_use_orig <= 1'b1;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + (IDX_W + 1)'(1);
            if (avail && (!r_found || cnt_rd < r_best)) begin
                r_found <= 1'b1;
                r_best  <= cnt_rd;
                r_sel   <= SEL_W'(addr);
            end
        end
        if (i_cmd.bump) begin
            r_use_orig <= !r_found;
            if (!r_found) r_sel <= '0;
        end
        if (i_cmd.rand_pick) begin
            r_sel      <= rand_sel;
            r_use_orig <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out.use_original <= r_use_orig;
            r_out.server_sel   <= r_sel;
            r_out.dest_out     <= r_dest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_SERVERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.rand_pick) begin
                r_lfsr <= lfsr_next(r_lfsr);
            end
            if ((i_cmd.scan && !avail) || (i_cmd.bump && r_found)) begin
                r_cnt[addr] <= cnt_sat;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/weighted_server_selector_core.sv
// ----------------------------------------------------------------------------
// weighted_server_selector_core
// Picks a pool server per request by weighted counters, round robin or LFSR.
// ----------------------------------------------------------------------------
// One request is handled at a time. A weighted or round-robin pick scans the
// n active servers, since one shared compare-and-update unit visits one server
// counter per cycle; a random pick and a pass-through request skip the scan.
// The result sits in an output register, so the next request is taken while
// it waits. Configuration registers take one write per cycle and are to be
// written only while no request is in flight; the block itself does not
// enforce this.
`default_nettype none

module weighted_server_selector_core
    import wsel_pkg::*;
#(
    parameter int MAX_SERVERS  = DEF_MAX_SERVERS,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [STEP_W-1:0]    i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_WEIGHTED;
            r_cfg.server_count <= '0;
            r_cfg.avail_mask   <= '1;
            r_cfg.step         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:       r_cfg.mode         <= i_cfg_data[1:0];
                CFG_SERVER_CNT: r_cfg.server_count <= i_cfg_data[2:0];
                CFG_AVAIL_MASK: r_cfg.avail_mask   <= i_cfg_data[3:0];
                CFG_STEP_ZERO:  r_cfg.step[0]      <= i_cfg_data;
                CFG_STEP_ONE:   r_cfg.step[1]      <= i_cfg_data;
                CFG_STEP_TWO:   r_cfg.step[2]      <= i_cfg_data;
                CFG_STEP_THREE: r_cfg.step[3]      <= i_cfg_data;
                default:        r_cfg              <= r_cfg;
            endcase
        end
    end

    wsel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    wsel_dp #(
        .MAX_SERVERS  (MAX_SERVERS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_orig_sel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.use_original) |-> (o_out.server_sel == '0))
        else $error("pass-through result carries a server index");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("new transaction taken while one is in progress");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no transaction in progress");

endmodule

`default_nettype wire

// File: dv/weighted_server_selector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_server_selector_core_tb
// Self-checking bench for the server selector. A scoreboard class keeps its
// own copy of the selection counters, the LFSR and the register settings,
// predicts the routing decision of every accepted request and compares it
// field by field with each result transaction. Directed requests cover the
// pass-through, no-server, oversized-count, random-mode and unused-mode
// cases; random phases follow, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

module weighted_server_selector_core_tb;
    import wsel_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int END_CYCLES  = 20;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 75;

    class route_scoreboard;
        logic [1:0]        mode;
        logic [2:0]        server_count;
        logic [3:0]        avail_mask;
        logic [STEP_W-1:0] step [4];
        logic [31:0]       counters [4];
        logic [15:0]       lfsr;
        t_out              pending_routes [$];
        int                errors;

        function new();
            errors = 0;
            mode = MODE_WEIGHTED;
            server_count = '0;
            avail_mask = 4'hF;
            for (int i = 0; i < 4; i++) begin
                step[i] = '0;
                counters[i] = '0;
            end
            lfsr = LFSR_SEED;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
            case (idx)
                CFG_MODE:       mode = data[1:0];
                CFG_SERVER_CNT: server_count = data[2:0];
                CFG_AVAIL_MASK: avail_mask = data[3:0];
                CFG_STEP_ZERO:  step[0] = data;
                CFG_STEP_ONE:   step[1] = data;
                CFG_STEP_TWO:   step[2] = data;
                CFG_STEP_THREE: step[3] = data;
                default: ;
            endcase
        endfunction

        function void add_saturating(int idx, logic [31:0] inc);
            if (counters[idx] > 32'hFFFF_FFFF - inc) begin
                counters[idx] = '1;
            end else begin
                counters[idx] = counters[idx] + inc;
            end
        endfunction

        function void note_request(t_in req);
            t_out        route;
            int          n;
            logic        found;
            logic [1:0]  sel;
            logic [31:0] inc;
            n = (server_count > 3'd4) ? 4 : int'(server_count);
            found = 1'b0;
            sel = '0;
            route.use_original = 1'b1;
            route.server_sel = '0;
            route.dest_out = req.original_dest;
            if (req.pool_hit && n > 0) begin
                if (mode == MODE_WEIGHTED || mode == MODE_ROUND_ROBIN) begin
                    for (int i = 0; i < n; i++) begin
                        inc = (mode == MODE_WEIGHTED) ? 32'(step[i]) : 32'd1;
                        if (!avail_mask[i]) begin
                            add_saturating(i, inc);
                        end else if (!found || counters[i] < counters[sel]) begin
                            found = 1'b1;
                            sel = 2'(i);
                        end
                    end
                    if (found) begin
                        add_saturating(sel, (mode == MODE_WEIGHTED) ? 32'(step[sel]) : 32'd1);
                        route.use_original = 1'b0;
                        route.server_sel = sel;
                    end
                end else if (mode == MODE_RANDOM && n >= 2) begin
                    route.server_sel = 2'(lfsr % 16'(n));
                    lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
                    route.use_original = 1'b0;
                end
            end
            pending_routes = {pending_routes, route};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_routes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = pending_routes.pop_front();
            if (got.use_original !== want.use_original) begin
                errors++;
                $display("%0t: use_original: expected %0b, actual %0b",
                         $time, want.use_original, got.use_original);
            end
            if (got.server_sel !== want.server_sel) begin
                errors++;
                $display("%0t: server_sel: expected %0d, actual %0d",
                         $time, want.server_sel, got.server_sel);
            end
            if (got.dest_out !== want.dest_out) begin
                errors++;
                $display("%0t: dest_out: expected %h, actual %h",
                         $time, want.dest_out, got.dest_out);
            end
        endfunction

        function int outstanding();
            return pending_routes.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [STEP_W-1:0]    i_cfg_data = '0;

    route_scoreboard sb;
    int idle_cycles = 0;
    int stall_left = 0;
    int stall_style = 0;
    int stall_hold = 0;

    weighted_server_selector_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_request(i_in);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("weighted_server_selector_core_tb failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_style)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 2) == 0);
            2: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    i_out_stall = 1'b1;
                end else begin
                    i_out_stall = 1'b0;
                    if ($urandom_range(0, 7) == 0) begin
                        stall_hold = $urandom_range(1, 12);
                    end
                end
            end
            default: i_out_stall = (stall_left % 3 == 0);
        endcase
    end

    task automatic send_request(input logic [31:0] dest, input logic hit);
        i_in_valid = 1'b1;
        i_in = '{original_dest: dest, pool_hit: hit};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_dest();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1000;
            2: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic randomise_config();
        logic [1:0] m;
        logic [2:0] cnt;
        int         r;
        r = $urandom_range(0, 19);
        m = (r < 8) ? MODE_WEIGHTED : (r < 13) ? MODE_ROUND_ROBIN
            : (r < 18) ? MODE_RANDOM : MODE_UNUSED;
        cnt = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
        program_reg(CFG_MODE, {8'($urandom), m});
        if ($urandom_range(0, 4) != 0) begin
            program_reg(CFG_SERVER_CNT, {7'($urandom), cnt});
        end
        if ($urandom_range(0, 4) != 0) begin
            program_reg(CFG_AVAIL_MASK, 10'($urandom));
        end
        if ($urandom_range(0, 2) != 0) begin
            program_reg(CFG_STEP_ZERO, pick_step());
            program_reg(CFG_STEP_ONE, pick_step());
            program_reg(CFG_STEP_TWO, pick_step());
            program_reg(CFG_STEP_THREE, pick_step());
        end
    endtask

    task automatic run_bursts(input int items);
        int left;
        int burst;
        int gap;
        left = items;
        while (left > 0) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_request(pick_dest(), $urandom_range(0, 99) < 85);
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            if ($urandom_range(0, 19) == 0) begin
                i_in_valid = 1'b0;
                wait_drained();
            end
        end
        i_in_valid = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        program_reg(CFG_MODE, {8'd0, MODE_WEIGHTED});
        program_reg(CFG_SERVER_CNT, 10'd4);
        program_reg(CFG_AVAIL_MASK, 10'hF);
        program_reg(CFG_STEP_ZERO, 10'd1000);
        program_reg(CFG_STEP_ONE, 10'd0);
        program_reg(CFG_STEP_TWO, 10'd500);
        program_reg(CFG_STEP_THREE, 10'd1023);
        send_request(32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b1);
        send_request(32'hA5A5_5A5A, 1'b1);
        send_request(32'h5A5A_A5A5, 1'b1);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h8000_0000, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        program_reg(CFG_AVAIL_MASK, 10'h0);
        send_request(32'h1234_5678, 1'b1);
        send_request(32'h8765_4321, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();
        program_reg(CFG_AVAIL_MASK, 10'h5);
        send_request(32'hDEAD_BEEF, 1'b1);
        send_request(32'hCAFE_F00D, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        program_reg(CFG_MODE, {8'd0, MODE_ROUND_ROBIN});
        program_reg(CFG_SERVER_CNT, 10'd7);
        program_reg(CFG_AVAIL_MASK, 10'hF);
        repeat (4) send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        program_reg(CFG_MODE, {8'd0, MODE_RANDOM});
        program_reg(CFG_SERVER_CNT, 10'd4);
        repeat (3) send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();
        program_reg(CFG_SERVER_CNT, 10'd1);
        send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();
        program_reg(CFG_SERVER_CNT, 10'd3);
        repeat (3) send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();
        program_reg(CFG_SERVER_CNT, 10'd2);
        repeat (2) send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        program_reg(CFG_MODE, {8'd0, MODE_UNUSED});
        send_request($urandom, 1'b1);
        i_in_valid = 1'b0;
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            randomise_config();
            run_bursts(PHASE_ITEMS);
            wait_drained();
        end

        repeat (END_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("weighted_server_selector_core_tb passed");
        end else begin
            $display("weighted_server_selector_core_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/wsel_pkg.sv
rtl/wsel_ctrl.sv
rtl/wsel_dp.sv
rtl/weighted_server_selector_core.sv
dv/weighted_server_selector_core_tb.sv
